>>> rtl/scc_pkg.sv
// Package: shared types, codes and constants for the sensor channel calibrator.
`default_nettype none
package scc_pkg;

  localparam int MASK_BITS      = 4;
  localparam int LIMIT_BITS     = 24;
  localparam int PCT_BITS       = 8;
  localparam int RATIO_BITS     = 16;
  localparam int SCALE_BITS     = 10;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  localparam logic [1:0] REQ_CAL  = 2'd0;
  localparam logic [1:0] REQ_MEAS = 2'd1;
  localparam logic [1:0] REQ_CLR  = 2'd2;

  localparam logic [1:0] ST_INIT     = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_ENZYME   = 2'd2;
  localparam logic [1:0] ST_VALUE    = 2'd3;

  localparam logic [1:0] VD_CONTINUE = 2'd0;
  localparam logic [1:0] VD_DONE     = 2'd1;
  localparam logic [1:0] VD_ERROR    = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE_MASK = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ERR_CHECK   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SWING_HI    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_HI     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SWING_LO    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AGREE_LO    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AGREE_HI    = 3'd6;

  localparam logic [LIMIT_BITS-1:0] RST_SWING_HI = 24'd8500000;
  localparam logic [LIMIT_BITS-1:0] RST_PEAK_HI  = 24'd15000000;
  localparam logic [LIMIT_BITS-1:0] RST_SWING_LO = 24'd10000;
  localparam logic [PCT_BITS-1:0]   RST_AGREE_LO = 8'd96;
  localparam logic [PCT_BITS-1:0]   RST_AGREE_HI = 8'd103;

  typedef struct packed {
    logic [MASK_BITS-1:0]  enable_mask;
    logic                  err_check;
    logic [LIMIT_BITS-1:0] swing_hi;
    logic [LIMIT_BITS-1:0] peak_hi;
    logic [LIMIT_BITS-1:0] swing_lo;
    logic [PCT_BITS-1:0]   agree_lo;
    logic [PCT_BITS-1:0]   agree_hi;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/scc_if.sv
// Interfaces: sample input channel and result output channel.
`default_nettype none
interface scc_in_if #(parameter int FREQ_BITS = 24) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [1:0]           channel;
  logic [FREQ_BITS-1:0] peak_freq;
  logic [FREQ_BITS-1:0] floor_freq;
  logic [FREQ_BITS-1:0] swing_freq;

  modport source(output valid, req_type, channel, peak_freq, floor_freq, swing_freq,
                 input ready);
  modport sink(input valid, req_type, channel, peak_freq, floor_freq, swing_freq,
               output ready);
endinterface

interface scc_out_if ();
  logic                            valid;
  logic                            ready;
  logic [1:0]                      out_channel;
  logic [1:0]                      cal_status;
  logic [1:0]                      cal_count;
  logic [scc_pkg::RATIO_BITS-1:0]  ratio_value;
  logic                            divide_error;
  logic [1:0]                      verdict;

  modport source(output valid, out_channel, cal_status, cal_count, ratio_value,
                 divide_error, verdict, input ready);
  modport sink(input valid, out_channel, cal_status, cal_count, ratio_value,
               divide_error, verdict, output ready);
endinterface
`default_nettype wire

>>> rtl/scc_cfg_regs.sv
// Configuration register bank with reset values.
`default_nettype none
module scc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [scc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [scc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output scc_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_mask <= '0;
      cfg.err_check   <= 1'b1;
      cfg.swing_hi    <= scc_pkg::RST_SWING_HI;
      cfg.peak_hi     <= scc_pkg::RST_PEAK_HI;
      cfg.swing_lo    <= scc_pkg::RST_SWING_LO;
      cfg.agree_lo    <= scc_pkg::RST_AGREE_LO;
      cfg.agree_hi    <= scc_pkg::RST_AGREE_HI;
    end else if (cfg_we) begin
      case (cfg_index)
        scc_pkg::CFG_ENABLE_MASK: cfg.enable_mask <= cfg_data[scc_pkg::MASK_BITS-1:0];
        scc_pkg::CFG_ERR_CHECK:   cfg.err_check   <= cfg_data[0];
        scc_pkg::CFG_SWING_HI:    cfg.swing_hi    <= cfg_data[scc_pkg::LIMIT_BITS-1:0];
        scc_pkg::CFG_PEAK_HI:     cfg.peak_hi     <= cfg_data[scc_pkg::LIMIT_BITS-1:0];
        scc_pkg::CFG_SWING_LO:    cfg.swing_lo    <= cfg_data[scc_pkg::LIMIT_BITS-1:0];
        scc_pkg::CFG_AGREE_LO:    cfg.agree_lo    <= cfg_data[scc_pkg::PCT_BITS-1:0];
        scc_pkg::CFG_AGREE_HI:    cfg.agree_hi    <= cfg_data[scc_pkg::PCT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/scc_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module scc_divider #(
  parameter int DIVIDEND_BITS = 34,
  parameter int DIVISOR_BITS  = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNTW = $clog2(DIVIDEND_BITS + 1);

  logic                    busy;
  logic [CNTW-1:0]         cnt;
  logic [DIVISOR_BITS-1:0] dsr;
  logic [DIVISOR_BITS:0]   rem;
  logic [DIVISOR_BITS:0]   shifted;
  logic [DIVISOR_BITS+1:0] diff;
  logic                    qbit;

  assign shifted = {rem[DIVISOR_BITS-1:0], quotient[DIVIDEND_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign qbit    = ~diff[DIVISOR_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DIVIDEND_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= qbit ? diff[DIVISOR_BITS:0] : shifted;
      quotient <= {quotient[DIVIDEND_BITS-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

>>> rtl/sensor_channel_calibrator_unit.sv
// Top level: sequencer, per-channel calibration state and result register.
// Path: S_EVAL then S_FIN for items without a divide; S_EVAL, S_DIV and
// S_FIN when a divide runs, with the shared bit-serial divider setting the
// time spent in S_DIV; S_FIN holds while the result is not taken.
// One item in flight; the next is accepted once the result is registered.
// Synchronous active-high reset: statuses init, counts and references zero.
`default_nettype none
module sensor_channel_calibrator_unit #(
  parameter int CHANNELS  = 4,
  parameter int FREQ_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [scc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [scc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  scc_in_if.sink                              sample,
  scc_out_if.source                           result
);

  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW   = (FREQ_BITS > scc_pkg::LIMIT_BITS) ? FREQ_BITS : scc_pkg::LIMIT_BITS;
  localparam int DDW  = FREQ_BITS + scc_pkg::SCALE_BITS;
  localparam int RW   = scc_pkg::RATIO_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  scc_pkg::cfg_t cfg;

  logic [1:0]           state;
  logic [1:0]           req;
  logic [1:0]           ch;
  logic [FREQ_BITS-1:0] peak;
  logic [FREQ_BITS-1:0] floor_f;
  logic [FREQ_BITS-1:0] swing;
  logic [RW-1:0]        ratio;
  logic                 div_err;

  logic [1:0]           status [CHANNELS];
  logic [1:0]           count  [CHANNELS];
  logic [FREQ_BITS-1:0] refs   [CHANNELS];
  logic [1:0]           status_next [CHANNELS];
  logic [1:0]           count_next  [CHANNELS];
  logic [FREQ_BITS-1:0] refs_next   [CHANNELS];

  logic                 out_valid;
  logic [1:0]           out_channel, out_status, out_count, out_verdict;
  logic [RW-1:0]        out_ratio;
  logic                 out_div_err;

  logic [IDXW-1:0]      idx;
  logic                 ch_valid, upper_ok, lower_ok, good, cal_act, cal_second;
  logic                 ref_zero, need_div, agree_fail, fin_go, out_load;
  logic [1:0]           st_cur, cnt_cur, cnt_inc;
  logic [FREQ_BITS-1:0] ref_cur, diff;
  logic [DDW-1:0]       x_ext, dividend, quotient;
  logic                 div_start, div_done;
  logic [RW-1:0]        q_sat;
  logic [CHANNELS-1:0]  en_vec;
  logic                 all_done, known_err;
  logic [1:0]           verdict_next;

  scc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign ch_valid = (32'(ch) < 32'(CHANNELS));
  assign idx      = IDXW'(ch);
  assign st_cur   = status[idx];
  assign cnt_cur  = count[idx];
  assign ref_cur  = refs[idx];
  assign cnt_inc  = cnt_cur + 2'd1;
  assign ref_zero = (ref_cur == '0);

  assign upper_ok = (CW'(swing) < CW'(cfg.swing_hi)) && (CW'(peak) < CW'(cfg.peak_hi));
  assign lower_ok = (CW'(swing) > CW'(cfg.swing_lo));
  assign good     = upper_ok && lower_ok;
  assign cal_act  = (req == scc_pkg::REQ_CAL) && ch_valid && cfg.enable_mask[ch]
                    && (st_cur == scc_pkg::ST_INIT);
  assign cal_second = cal_act && good && (cnt_inc == 2'd2);
  assign need_div   = (cal_second || ((req == scc_pkg::REQ_MEAS) && ch_valid)) && !ref_zero;

  // x*1000 = x*1024 - x*16 - x*8 ; x*100 = x*64 + x*32 + x*4
  assign diff  = peak - floor_f;
  assign x_ext = DDW'((req == scc_pkg::REQ_MEAS) ? diff : swing);
  assign dividend = (req == scc_pkg::REQ_MEAS)
                    ? (x_ext << 10) - (x_ext << 4) - (x_ext << 3)
                    : (x_ext << 6) + (x_ext << 5) + (x_ext << 2);
  assign div_start = (state == S_EVAL) && need_div;

  scc_divider #(
    .DIVIDEND_BITS (DDW),
    .DIVISOR_BITS  (FREQ_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (ref_cur),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_sat = (|quotient[DDW-1:RW]) ? '1 : quotient[RW-1:0];

  assign agree_fail = (ratio <= RW'(cfg.agree_lo)) || (ratio >= RW'(cfg.agree_hi));
  assign fin_go     = !out_valid || result.ready;
  assign out_load   = (state == S_FIN) && fin_go;
  assign sample.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (sample.valid) state <= S_EVAL;
        S_EVAL: state <= need_div ? S_DIV : S_FIN;
        S_DIV:  if (div_done) state <= S_FIN;
        S_FIN:  if (fin_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      req     <= sample.req_type;
      ch      <= sample.channel;
      peak    <= sample.peak_freq;
      floor_f <= sample.floor_freq;
      swing   <= sample.swing_freq;
    end
    if (state == S_EVAL) begin
      ratio   <= cal_second ? '1 : '0;
      div_err <= (req == scc_pkg::REQ_MEAS) && (!ch_valid || ref_zero);
    end else if ((state == S_DIV) && div_done) begin
      ratio <= q_sat;
    end
  end

  always_comb begin
    status_next = status;
    count_next  = count;
    refs_next   = refs;
    if (out_load) begin
      if (cal_act) begin
        if (upper_ok) begin
          if (lower_ok) begin
            count_next[idx] = cnt_inc;
            if (cnt_inc == 2'd1) begin
              refs_next[idx] = swing;
            end else if (cnt_inc == 2'd2) begin
              refs_next[idx] = swing;
              if (agree_fail) begin
                count_next[idx] = 2'd1;
              end else begin
                count_next[idx]  = 2'd0;
                status_next[idx] = scc_pkg::ST_FINISHED;
              end
            end
          end else if (cfg.err_check) begin
            count_next[idx]  = 2'd0;
            status_next[idx] = scc_pkg::ST_ENZYME;
          end
        end else if (cfg.err_check) begin
          count_next[idx]  = 2'd0;
          status_next[idx] = scc_pkg::ST_VALUE;
        end
      end
      if (req == scc_pkg::REQ_CLR) begin
        for (int i = 0; i < CHANNELS; i++) begin
          status_next[i] = scc_pkg::ST_INIT;
          count_next[i]  = 2'd0;
        end
      end
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_en
    if (g < scc_pkg::MASK_BITS) begin : g_has
      assign en_vec[g] = cfg.enable_mask[g];
    end else begin : g_none
      assign en_vec[g] = 1'b0;
    end
  end

  always_comb begin
    all_done  = 1'b1;
    known_err = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (en_vec[i] && (status_next[i] != scc_pkg::ST_FINISHED)) all_done = 1'b0;
      if ((status_next[i] == scc_pkg::ST_ENZYME) || (status_next[i] == scc_pkg::ST_VALUE))
        known_err = 1'b1;
    end
    if (all_done) verdict_next = scc_pkg::VD_DONE;
    else if (known_err) verdict_next = scc_pkg::VD_ERROR;
    else verdict_next = scc_pkg::VD_CONTINUE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        status[i] <= scc_pkg::ST_INIT;
        count[i]  <= 2'd0;
        refs[i]   <= '0;
      end
    end else begin
      status <= status_next;
      count  <= count_next;
      refs   <= refs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel <= ch;
      out_status  <= ch_valid ? status_next[idx] : scc_pkg::ST_INIT;
      out_count   <= ch_valid ? count_next[idx] : 2'd0;
      out_ratio   <= ratio;
      out_div_err <= div_err;
      out_verdict <= verdict_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.out_channel  = out_channel;
  assign result.cal_status   = out_status;
  assign result.cal_count    = out_count;
  assign result.ratio_value  = out_ratio;
  assign result.divide_error = out_div_err;
  assign result.verdict      = out_verdict;

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> state == S_EVAL)
    else $error("accepted transaction did not enter evaluation");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_err_no_ratio: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.divide_error && (result.ratio_value != '0)))
    else $error("divide error reported with a nonzero ratio");

  a_status_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.cal_status != scc_pkg::ST_INIT) |-> result.cal_count == 2'd0)
    else $error("nonzero count on a channel out of init");

endmodule
`default_nettype wire
